[rtl/core/dfc_pkg.sv]
// dfc_pkg: shared types and constants for the direct-form convolution block
// no dependencies; imported by every module in rtl/core
`timescale 1ns / 1ps
`default_nettype none

package dfc_pkg;

  localparam int unsigned DFC_MAX_TAPS = 64;
  localparam int unsigned DFC_VAL_W    = 16;
  localparam int unsigned DFC_PROD_W   = 32;
  localparam int unsigned DFC_ACC_W    = 38;
  localparam int unsigned DFC_TDATA_IN_W  = 16;
  localparam int unsigned DFC_TDATA_OUT_W = 40;

  localparam logic REQ_TAP    = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } dfc_state_e;

  typedef struct packed {
    logic clear;
    logic rd_valid;
    logic rd_keep;
  } mac_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/dfc_store.sv]
// dfc_store: tap memory and circular sample history, registered reads
// depends on dfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfc_store
  import dfc_pkg::*;
#(
  parameter int unsigned MAX_TAPS = DFC_MAX_TAPS,
  localparam int unsigned AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int unsigned HD = 2 ** AW
) (
  input  wire logic                        clk_i,
  input  wire logic                        tap_we_i,
  input  wire logic [AW-1:0]               tap_waddr_i,
  input  wire logic signed [DFC_VAL_W-1:0] tap_wdata_i,
  input  wire logic [AW-1:0]               tap_raddr_i,
  output logic signed [DFC_VAL_W-1:0]      tap_rdata_o,
  input  wire logic                        hist_we_i,
  input  wire logic [AW-1:0]               hist_waddr_i,
  input  wire logic signed [DFC_VAL_W-1:0] hist_wdata_i,
  input  wire logic [AW-1:0]               hist_raddr_i,
  output logic signed [DFC_VAL_W-1:0]      hist_rdata_o
);

  logic signed [DFC_VAL_W-1:0] tap_mem [MAX_TAPS];
  logic signed [DFC_VAL_W-1:0] hist_mem [HD];

  always_ff @(posedge clk_i) begin
    if (tap_we_i) begin
      tap_mem[tap_waddr_i] <= tap_wdata_i;
    end
    tap_rdata_o <= tap_mem[tap_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we_i) begin
      hist_mem[hist_waddr_i] <= hist_wdata_i;
    end
    hist_rdata_o <= hist_mem[hist_raddr_i];
  end

endmodule

`default_nettype wire

[rtl/core/dfc_mac.sv]
// dfc_mac: shared multiply-accumulate unit, product register then accumulator
// depends on dfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfc_mac
  import dfc_pkg::*;
(
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mac_ctrl_t                   ctrl_i,
  input  wire logic signed [DFC_VAL_W-1:0] tap_i,
  input  wire logic signed [DFC_VAL_W-1:0] hist_i,
  output logic signed [DFC_ACC_W-1:0]      acc_o,
  output logic                             busy_o
);

  logic signed [DFC_PROD_W-1:0] prod_d, prod_q;
  logic                         prod_v_q;
  logic signed [DFC_ACC_W-1:0]  acc_d, acc_q;

  always_comb begin
    prod_d = '0;
    if (ctrl_i.rd_keep) begin
      prod_d = tap_i * hist_i;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + {{(DFC_ACC_W-DFC_PROD_W){prod_q[DFC_PROD_W-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= ctrl_i.rd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_v_q;

endmodule

`default_nettype wire

[rtl/core/dfc_seq.sv]
// dfc_seq: sequencer for tap loads, history pushes, tap walk and output register
// depends on dfc_pkg; drives dfc_store and dfc_mac
`timescale 1ns / 1ps
`default_nettype none

module dfc_seq
  import dfc_pkg::*;
#(
  parameter int unsigned MAX_TAPS = DFC_MAX_TAPS,
  localparam int unsigned AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int unsigned CW = $clog2(MAX_TAPS + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        in_type_i,
  input  wire logic signed [DFC_VAL_W-1:0] in_value_i,
  input  wire logic                        in_final_i,
  output logic                             tap_we_o,
  output logic [AW-1:0]                    tap_waddr_o,
  output logic [AW-1:0]                    tap_raddr_o,
  output logic                             hist_we_o,
  output logic [AW-1:0]                    hist_waddr_o,
  output logic signed [DFC_VAL_W-1:0]      hist_wdata_o,
  output logic [AW-1:0]                    hist_raddr_o,
  output mac_ctrl_t                        mac_ctrl_o,
  input  wire logic signed [DFC_ACC_W-1:0] acc_i,
  input  wire logic                        mac_busy_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [DFC_ACC_W-1:0]      out_value_o,
  output logic                             out_last_o
);

  dfc_state_e state_q, state_d;

  logic [CW-1:0] tap_count_q;
  logic          set_used_q;
  logic          active_q;
  logic [CW-1:0] fill_q;
  logic [AW-1:0] wp_q;
  logic [CW-1:0] j_q;
  logic [CW-1:0] tail_q;
  logic          fin_q;
  logic signed [DFC_VAL_W-1:0] push_val_q;
  logic          rd_v_q, rd_keep_q;
  logic          ov_q, olast_q;
  logic signed [DFC_ACC_W-1:0] oval_q;

  logic in_fire, tap_fire, smp_go, issue, do_load, last_issue;

  assign in_fire    = in_valid_i && in_ready_o;
  assign tap_fire   = in_fire && (in_type_i == REQ_TAP) && !active_q;
  assign smp_go     = in_fire && (in_type_i == REQ_SAMPLE) && (tap_count_q != '0);
  assign last_issue = (j_q == tap_count_q - CW'(1));
  assign do_load    = (state_q == ST_OUT) && (!ov_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (smp_go) state_d = ST_PUSH;
      ST_PUSH:  state_d = ST_MAC;
      ST_MAC:   if (last_issue) state_d = ST_DRAIN;
      ST_DRAIN: if (!rd_v_q && !mac_busy_i) state_d = ST_OUT;
      ST_OUT: begin
        if (do_load) state_d = (tail_q == '0) ? ST_IDLE : ST_PUSH;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    hist_we_o  = 1'b0;
    issue      = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_PUSH:  hist_we_o  = 1'b1;
      ST_MAC:   issue      = 1'b1;
      ST_DRAIN: ;
      ST_OUT:   ;
      default:  ;
    endcase
  end

  assign tap_we_o     = tap_fire && (set_used_q || (tap_count_q < CW'(MAX_TAPS)));
  assign tap_waddr_o  = set_used_q ? '0 : tap_count_q[AW-1:0];
  assign tap_raddr_o  = j_q[AW-1:0];
  assign hist_waddr_o = wp_q + AW'(1);
  assign hist_wdata_o = push_val_q;
  assign hist_raddr_o = wp_q - j_q[AW-1:0];

  // clear, rd_valid, rd_keep from the top bit down
  assign mac_ctrl_o = {hist_we_o, rd_v_q, rd_keep_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_count_q <= '0;
      set_used_q  <= 1'b0;
      active_q    <= 1'b0;
      fill_q      <= '0;
      wp_q        <= '0;
      j_q         <= '0;
      tail_q      <= '0;
      fin_q       <= 1'b0;
      rd_v_q      <= 1'b0;
      rd_keep_q   <= 1'b0;
      ov_q        <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_v_q    <= issue;
      rd_keep_q <= issue && (j_q < fill_q);
      if (tap_fire) begin
        if (set_used_q) begin
          tap_count_q <= CW'(1);
          set_used_q  <= 1'b0;
        end else if (tap_count_q < CW'(MAX_TAPS)) begin
          tap_count_q <= tap_count_q + CW'(1);
        end
      end
      if (smp_go) begin
        fin_q  <= in_final_i;
        tail_q <= in_final_i ? tap_count_q - CW'(1) : '0;
        if (!active_q) begin
          active_q <= 1'b1;
          fill_q   <= '0;
        end
      end
      if (hist_we_o) begin
        wp_q <= wp_q + AW'(1);
        j_q  <= '0;
        if (fill_q < tap_count_q) fill_q <= fill_q + CW'(1);
      end
      if (issue) j_q <= j_q + CW'(1);
      if (out_valid_o && out_ready_i && !do_load) ov_q <= 1'b0;
      if (do_load) begin
        ov_q <= 1'b1;
        if (tail_q == '0) begin
          if (fin_q) begin
            active_q   <= 1'b0;
            set_used_q <= 1'b1;
          end
        end else begin
          tail_q <= tail_q - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_go) push_val_q <= in_value_i;
    else if (do_load) push_val_q <= '0;
    if (do_load) begin
      oval_q  <= acc_i;
      olast_q <= fin_q && (tail_q == '0);
    end
  end

  assign out_valid_o = ov_q;
  assign out_value_o = oval_q;
  assign out_last_o  = olast_q;

endmodule

`default_nettype wire

[rtl/core/direct_form_convolution_top.sv]
// sequence: a sample with L taps is pushed into the history, its taps are walked and the
// MAC drains before the output loads; a final sample adds L-1 tail outputs with zero pushes
// throughput: one shared multiply-accumulate walks the taps, one tap per cycle
// reset: rst_ni asynchronous active low, clears tap count and signal state
// top level: instantiates dfc_seq, dfc_store and dfc_mac; depends on dfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module direct_form_convolution_top
  import dfc_pkg::*;
#(
  parameter int unsigned MAX_TAPS = DFC_MAX_TAPS,
  localparam int unsigned AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [DFC_TDATA_IN_W-1:0]  s_axis_tdata,   // [15:0] value
  input  wire logic                       s_axis_tuser,   // [0] req_type
  input  wire logic                       s_axis_tlast,   // final_sample
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [DFC_TDATA_OUT_W-1:0]      m_axis_tdata,   // [37:0] out_value, zero pad
  output logic                            m_axis_tlast    // out_last
);

  logic                        tap_we, hist_we;
  logic [AW-1:0]               tap_waddr, tap_raddr, hist_waddr, hist_raddr;
  logic signed [DFC_VAL_W-1:0] hist_wdata, tap_rdata, hist_rdata;
  mac_ctrl_t                   mac_ctrl;
  logic signed [DFC_ACC_W-1:0] acc, out_value;
  logic                        mac_busy;

  dfc_seq #(.MAX_TAPS(MAX_TAPS)) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_type_i    (s_axis_tuser),
    .in_value_i   (s_axis_tdata[DFC_VAL_W-1:0]),
    .in_final_i   (s_axis_tlast),
    .tap_we_o     (tap_we),
    .tap_waddr_o  (tap_waddr),
    .tap_raddr_o  (tap_raddr),
    .hist_we_o    (hist_we),
    .hist_waddr_o (hist_waddr),
    .hist_wdata_o (hist_wdata),
    .hist_raddr_o (hist_raddr),
    .mac_ctrl_o   (mac_ctrl),
    .acc_i        (acc),
    .mac_busy_i   (mac_busy),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (out_value),
    .out_last_o   (m_axis_tlast)
  );

  dfc_store #(.MAX_TAPS(MAX_TAPS)) u_store (
    .clk_i        (clk_i),
    .tap_we_i     (tap_we),
    .tap_waddr_i  (tap_waddr),
    .tap_wdata_i  (s_axis_tdata[DFC_VAL_W-1:0]),
    .tap_raddr_i  (tap_raddr),
    .tap_rdata_o  (tap_rdata),
    .hist_we_i    (hist_we),
    .hist_waddr_i (hist_waddr),
    .hist_wdata_i (hist_wdata),
    .hist_raddr_i (hist_raddr),
    .hist_rdata_o (hist_rdata)
  );

  dfc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .tap_i  (tap_rdata),
    .hist_i (hist_rdata),
    .acc_o  (acc),
    .busy_o (mac_busy)
  );

  assign m_axis_tdata = {{(DFC_TDATA_OUT_W-DFC_ACC_W){1'b0}}, out_value};

endmodule

`default_nettype wire

[rtl/core/dfc_checker.sv]
// dfc_checker: port-level assertions for direct_form_convolution_top, with bind
// depends on dfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfc_checker
  import dfc_pkg::*;
(
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       s_axis_tvalid,
  input wire logic                       s_axis_tready,
  input wire logic                       s_axis_tuser,
  input wire logic                       m_axis_tvalid,
  input wire logic                       m_axis_tready,
  input wire logic [DFC_TDATA_OUT_W-1:0] m_axis_tdata,
  input wire logic                       m_axis_tlast
);

  logic s_fire;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // a tap beat never stalls the input
  a_tap_keeps_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == REQ_TAP) |=> s_axis_tready)
    else $error("input stalled after tap beat");

  // a sample beat must not raise the output valid too early
  a_sample_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && (s_axis_tuser == REQ_SAMPLE) |=> !$rose(m_axis_tvalid) ##1 !$rose(m_axis_tvalid))
    else $error("output beat too early after sample beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

endmodule

bind direct_form_convolution_top dfc_checker u_dfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
